// ----- hdl/tpi_pkg.sv -----
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared types, constants and width helpers of the three-plane intersection.
// ----------------------------------------------------------------------------
package tpi_pkg;

    localparam int NORMAL_W             = 16;
    localparam int DIST_W               = 32;
    localparam int COORD_W              = 32;
    localparam int MIN_DEN_W            = 50;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int DIV_STEPS            = 32;
    localparam logic [MIN_DEN_W-1:0] MIN_DEN_RESET = 50'd44;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_PARALLEL   = 2'd1,
        STATUS_DEGENERATE = 2'd2,
        STATUS_SATURATED  = 2'd3
    } tpi_status_t;

    typedef struct packed {
        logic par;
        logic deg;
    } tpi_flags_t;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] a_normal_x;
        logic signed [NORMAL_W-1:0] a_normal_y;
        logic signed [NORMAL_W-1:0] a_normal_z;
        logic signed [DIST_W-1:0]   a_distance;
        logic signed [NORMAL_W-1:0] b_normal_x;
        logic signed [NORMAL_W-1:0] b_normal_y;
        logic signed [NORMAL_W-1:0] b_normal_z;
        logic signed [DIST_W-1:0]   b_distance;
        logic signed [NORMAL_W-1:0] c_normal_x;
        logic signed [NORMAL_W-1:0] c_normal_y;
        logic signed [NORMAL_W-1:0] c_normal_z;
        logic signed [DIST_W-1:0]   c_distance;
    } tpi_planes_t;

    // Width of the signed numerator of one axis.
    function automatic int tpi_num_w(input int nfb);
        int t1;
        t1 = 65 + 2 * nfb;
        return ((t1 > 99) ? t1 : 99) + 2;
    endfunction

    // Width of the scaled divisor |den| << nfb.
    function automatic int tpi_dv_w(input int nfb);
        return MIN_DEN_W + nfb;
    endfunction

endpackage

// ----- hdl/tpi_plane_if.sv -----
// ----------------------------------------------------------------------------
// tpi_plane_if
// Request channel carrying three planes.
// ----------------------------------------------------------------------------
interface tpi_plane_if;
    import tpi_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [NORMAL_W-1:0] a_normal_x;
    logic signed [NORMAL_W-1:0] a_normal_y;
    logic signed [NORMAL_W-1:0] a_normal_z;
    logic signed [DIST_W-1:0]   a_distance;
    logic signed [NORMAL_W-1:0] b_normal_x;
    logic signed [NORMAL_W-1:0] b_normal_y;
    logic signed [NORMAL_W-1:0] b_normal_z;
    logic signed [DIST_W-1:0]   b_distance;
    logic signed [NORMAL_W-1:0] c_normal_x;
    logic signed [NORMAL_W-1:0] c_normal_y;
    logic signed [NORMAL_W-1:0] c_normal_z;
    logic signed [DIST_W-1:0]   c_distance;

    modport source (
        output valid, a_normal_x, a_normal_y, a_normal_z, a_distance,
               b_normal_x, b_normal_y, b_normal_z, b_distance,
               c_normal_x, c_normal_y, c_normal_z, c_distance,
        input  ready
    );
    modport sink (
        input  valid, a_normal_x, a_normal_y, a_normal_z, a_distance,
               b_normal_x, b_normal_y, b_normal_z, b_distance,
               c_normal_x, c_normal_y, c_normal_z, c_distance,
        output ready
    );
endinterface

// ----- hdl/tpi_point_if.sv -----
// ----------------------------------------------------------------------------
// tpi_point_if
// Result channel carrying the status and the intersection point.
// ----------------------------------------------------------------------------
interface tpi_point_if;
    import tpi_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;

    modport source (output valid, status, point_x, point_y, point_z, input ready);
    modport sink (input valid, status, point_x, point_y, point_z, output ready);
endinterface

// ----- hdl/three_plane_intersection.sv -----
// ----------------------------------------------------------------------------
// three_plane_intersection
// Three-plane common point (Q16.16) with parallel/degenerate/saturated status.
//
//   Channel   Dir  Handshake      Carries
//   planes    in   valid/ready    three normals (Q2.14) and distances (Q16.16)
//   result    out  valid/ready    status and point_x/y/z (Q16.16)
//   cfg       in   cfg_wr_en      min_denominator (50 bits)
//
// One request per cycle is accepted unless a result held at the output
// stalls the whole pipeline; nothing is lost. It runs six arithmetic stages,
// a 33-stage restoring divider (entry stage, then one quotient bit per stage)
// and the output register. Reset clears the valid bits, presets min_den_reg.
// ----------------------------------------------------------------------------
module three_plane_intersection #(
    parameter int NORMAL_FRAC_BITS = tpi_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tpi_pkg::MIN_DEN_W-1:0] cfg_wr_data,
    tpi_plane_if.sink                     planes,
    tpi_point_if.source                   result
);
    import tpi_pkg::*;

    localparam int NP_W = tpi_num_w(NORMAL_FRAC_BITS) + 1;
    localparam int DP_W = tpi_dv_w(NORMAL_FRAC_BITS) + 1;
    localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] NEG_MAX = {1'b1, {(COORD_W-1){1'b0}}};

    logic                 en;
    logic [MIN_DEN_W-1:0] min_den_reg;
    tpi_planes_t          req;

    logic                 f_valid;
    tpi_flags_t           f_flags;
    logic [NP_W-1:0]      f_np [3];
    logic [DP_W-1:0]      f_dp;
    logic                 f_neg [3];

    logic                 d_valid;
    tpi_flags_t           d_flags;
    logic [COORD_W-1:0]   d_q [3];
    logic                 d_ovf [3];
    logic                 d_neg [3];

    logic                 sat [3];
    logic [COORD_W-1:0]   coord [3];
    tpi_status_t          status_next;

    logic                 out_valid_reg;
    tpi_status_t          status_reg;
    logic [COORD_W-1:0]   point_reg [3];

    assign en           = !out_valid_reg || result.ready;
    assign planes.ready = en;

    always_comb
    begin
        req.a_normal_x = planes.a_normal_x;
        req.a_normal_y = planes.a_normal_y;
        req.a_normal_z = planes.a_normal_z;
        req.a_distance = planes.a_distance;
        req.b_normal_x = planes.b_normal_x;
        req.b_normal_y = planes.b_normal_y;
        req.b_normal_z = planes.b_normal_z;
        req.b_distance = planes.b_distance;
        req.c_normal_x = planes.c_normal_x;
        req.c_normal_y = planes.c_normal_y;
        req.c_normal_z = planes.c_normal_z;
        req.c_distance = planes.c_distance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_den_reg <= MIN_DEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            min_den_reg <= cfg_wr_data;
        end
    end

    tpi_front #(.NFB(NORMAL_FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (planes.valid),
        .planes    (req),
        .min_den   (min_den_reg),
        .out_valid (f_valid),
        .flags     (f_flags),
        .np        (f_np),
        .dp        (f_dp),
        .neg       (f_neg)
    );

    tpi_divider #(.NFB(NORMAL_FRAC_BITS)) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_flags  (f_flags),
        .np        (f_np),
        .dp        (f_dp),
        .in_neg    (f_neg),
        .out_valid (d_valid),
        .out_flags (d_flags),
        .q         (d_q),
        .ovf       (d_ovf),
        .out_neg   (d_neg)
    );

    // A negative result may reach one step further than a positive one.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sat[k] = d_ovf[k] || (d_neg[k] ? (d_q[k] > NEG_MAX) : d_q[k][COORD_W-1]);
            if (d_flags.par || d_flags.deg)
            begin
                coord[k] = '0;
            end
            else if (sat[k])
            begin
                coord[k] = d_neg[k] ? NEG_MAX : POS_MAX;
            end
            else
            begin
                coord[k] = d_neg[k] ? -d_q[k] : d_q[k];
            end
        end
        if (d_flags.par)
        begin
            status_next = STATUS_PARALLEL;
        end
        else if (d_flags.deg)
        begin
            status_next = STATUS_DEGENERATE;
        end
        else if (sat[0] || sat[1] || sat[2])
        begin
            status_next = STATUS_SATURATED;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= status_next;
            point_reg  <= coord;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.status  = status_reg;
    assign result.point_x = point_reg[0];
    assign result.point_y = point_reg[1];
    assign result.point_z = point_reg[2];

    a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == STATUS_PARALLEL ||
                         result.status == STATUS_DEGENERATE)
        |-> (result.point_x == '0 && result.point_y == '0 && result.point_z == '0))
        else $error("rejected request carries a nonzero point");

    a_saturated_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == STATUS_SATURATED
        |-> (result.point_x == POS_MAX || result.point_x == NEG_MAX ||
             result.point_y == POS_MAX || result.point_y == NEG_MAX ||
             result.point_z == POS_MAX || result.point_z == NEG_MAX))
        else $error("saturated status without a clamped coordinate");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !planes.ready)
        else $error("request accepted while the pipeline is stalled");

endmodule

// ----- hdl/tpi_front.sv -----
// ----------------------------------------------------------------------------
// tpi_front
// Six-stage pipeline: products, dot and cross sums, numerators, divisor, the
// parallel and degenerate checks, rounded dividend and divisor magnitudes.
// ----------------------------------------------------------------------------
module tpi_front #(
    parameter int NFB = tpi_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            en,
    input  logic                                            in_valid,
    input  tpi_pkg::tpi_planes_t                            planes,
    input  logic [tpi_pkg::MIN_DEN_W-1:0]                   min_den,
    output logic                                            out_valid,
    output tpi_pkg::tpi_flags_t                             flags,
    output logic [tpi_pkg::tpi_num_w(NFB):0]                np [3],
    output logic [tpi_pkg::tpi_dv_w(NFB):0]                 dp,
    output logic                                            neg [3]
);
    import tpi_pkg::*;

    localparam int NUM_W = tpi_num_w(NFB);
    localparam int DV_W  = tpi_dv_w(NFB);
    localparam int NP_W  = NUM_W + 1;
    localparam int SH    = 2 * NFB;
    localparam logic signed [63:0] ONE = 64'sd1 <<< SH;
    localparam int unsigned NEXT1 [3] = '{1, 2, 0};
    localparam int unsigned NEXT2 [3] = '{2, 0, 1};

    function automatic logic too_big(input logic signed [33:0] d);
        logic signed [63:0] w;
        w = 64'(d);
        return (w >= ONE) || (-w >= ONE);
    endfunction

    logic signed [NORMAL_W-1:0] na [3];
    logic signed [NORMAL_W-1:0] nb [3];
    logic signed [NORMAL_W-1:0] nc [3];

    // Stage 1
    logic                       v1_reg;
    logic signed [31:0]         ab_reg [3], ac_reg [3], bc_reg [3], cc_reg [3];
    logic signed [31:0]         lp_reg [3], lm_reg [3];
    logic signed [31:0]         c1p_reg [3], c1m_reg [3], c2p_reg [3], c2m_reg [3];
    logic signed [NORMAL_W-1:0] nc1_reg [3];
    logic signed [DIST_W-1:0]   da1_reg, db1_reg, dc1_reg;
    // Stage 2
    logic                       v2_reg;
    logic signed [33:0]         dab_reg, dac_reg, dbc_reg, nc2_reg;
    logic signed [32:0]         l2_reg [3], c1_reg [3], c2_reg [3];
    logic signed [NORMAL_W-1:0] nc2v_reg [3];
    logic signed [DIST_W-1:0]   da2_reg, db2_reg, dc2_reg;
    // Stage 3
    logic                       v3_reg, par3_reg;
    logic signed [48:0]         dn_reg [3];
    logic signed [64:0]         t1_reg [3], t2_reg [3];
    logic signed [65:0]         t_reg;
    logic signed [32:0]         l3_reg [3];
    // Stage 4
    logic                       v4_reg, par4_reg;
    logic signed [50:0]         den4_reg;
    logic signed [66:0]         plo_reg [3];
    logic signed [65:0]         phi_reg [3];
    logic signed [64:0]         t1b_reg [3], t2b_reg [3];
    // Stage 5
    logic                       v5_reg, par5_reg, deg5_reg, dneg5_reg;
    logic signed [NUM_W-1:0]    num5_reg [3];
    logic [DV_W-1:0]            dv5_reg;
    // Stage 6
    logic                       v6_reg;
    tpi_flags_t                 flags6_reg;
    logic [NP_W-1:0]            np6_reg [3];
    logic [DV_W:0]              dp6_reg;
    logic                       neg6_reg [3];

    logic [MIN_DEN_W-1:0]       den_abs;
    logic [NUM_W-1:0]           nabs [3];

    always_comb
    begin
        na[0] = planes.a_normal_x; na[1] = planes.a_normal_y; na[2] = planes.a_normal_z;
        nb[0] = planes.b_normal_x; nb[1] = planes.b_normal_y; nb[2] = planes.b_normal_z;
        nc[0] = planes.c_normal_x; nc[1] = planes.c_normal_y; nc[2] = planes.c_normal_z;
        den_abs = den4_reg[50] ? MIN_DEN_W'(-den4_reg) : MIN_DEN_W'(den4_reg);
        for (int k = 0; k < 3; k++)
        begin
            nabs[k] = num5_reg[k][NUM_W-1] ? NUM_W'(-num5_reg[k]) : NUM_W'(num5_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ab_reg[k]  <= na[k] * nb[k];
                ac_reg[k]  <= na[k] * nc[k];
                bc_reg[k]  <= nb[k] * nc[k];
                cc_reg[k]  <= nc[k] * nc[k];
                lp_reg[k]  <= na[NEXT1[k]] * nb[NEXT2[k]];
                lm_reg[k]  <= na[NEXT2[k]] * nb[NEXT1[k]];
                c1p_reg[k] <= nb[NEXT1[k]] * nc[NEXT2[k]];
                c1m_reg[k] <= nb[NEXT2[k]] * nc[NEXT1[k]];
                c2p_reg[k] <= nc[NEXT1[k]] * na[NEXT2[k]];
                c2m_reg[k] <= nc[NEXT2[k]] * na[NEXT1[k]];
                nc1_reg[k] <= nc[k];
            end
            da1_reg <= planes.a_distance;
            db1_reg <= planes.b_distance;
            dc1_reg <= planes.c_distance;

            dab_reg <= 34'(ab_reg[0]) + 34'(ab_reg[1]) + 34'(ab_reg[2]);
            dac_reg <= 34'(ac_reg[0]) + 34'(ac_reg[1]) + 34'(ac_reg[2]);
            dbc_reg <= 34'(bc_reg[0]) + 34'(bc_reg[1]) + 34'(bc_reg[2]);
            nc2_reg <= 34'(cc_reg[0]) + 34'(cc_reg[1]) + 34'(cc_reg[2]);
            for (int k = 0; k < 3; k++)
            begin
                l2_reg[k]   <= 33'(lp_reg[k]) - 33'(lm_reg[k]);
                c1_reg[k]   <= 33'(c1p_reg[k]) - 33'(c1m_reg[k]);
                c2_reg[k]   <= 33'(c2p_reg[k]) - 33'(c2m_reg[k]);
                nc2v_reg[k] <= nc1_reg[k];
            end
            da2_reg <= da1_reg;
            db2_reg <= db1_reg;
            dc2_reg <= dc1_reg;

            par3_reg <= too_big(dab_reg) || too_big(dac_reg) || too_big(dbc_reg);
            for (int k = 0; k < 3; k++)
            begin
                dn_reg[k] <= nc2v_reg[k] * l2_reg[k];
                t1_reg[k] <= da2_reg * c1_reg[k];
                t2_reg[k] <= db2_reg * c2_reg[k];
                l3_reg[k] <= l2_reg[k];
            end
            t_reg <= dc2_reg * nc2_reg;

            // The third term is dc*|nc|^2*l; its wide factor is split in two.
            par4_reg <= par3_reg;
            den4_reg <= 51'(dn_reg[0]) + 51'(dn_reg[1]) + 51'(dn_reg[2]);
            for (int k = 0; k < 3; k++)
            begin
                plo_reg[k] <= $signed({1'b0, t_reg[32:0]}) * l3_reg[k];
                phi_reg[k] <= $signed(t_reg[65:33]) * l3_reg[k];
                t1b_reg[k] <= t1_reg[k];
                t2b_reg[k] <= t2_reg[k];
            end

            par5_reg  <= par4_reg;
            deg5_reg  <= den_abs <= min_den;
            dneg5_reg <= den4_reg[50];
            dv5_reg   <= DV_W'(den_abs) << NFB;
            for (int k = 0; k < 3; k++)
            begin
                num5_reg[k] <= (NUM_W'(t1b_reg[k]) <<< SH) + (NUM_W'(t2b_reg[k]) <<< SH)
                             + (NUM_W'(phi_reg[k]) <<< 33) + NUM_W'(plo_reg[k]);
            end

            // Round to nearest: floor((2|n| + d) / 2d).
            flags6_reg.par <= par5_reg;
            flags6_reg.deg <= deg5_reg;
            dp6_reg        <= {dv5_reg, 1'b0};
            for (int k = 0; k < 3; k++)
            begin
                np6_reg[k]  <= {nabs[k], 1'b0} + NP_W'(dv5_reg);
                neg6_reg[k] <= num5_reg[k][NUM_W-1] ^ dneg5_reg;
            end
        end
    end

    assign out_valid = v6_reg;
    assign flags     = flags6_reg;
    assign dp        = dp6_reg;
    assign np        = np6_reg;
    assign neg       = neg6_reg;

endmodule

// ----- hdl/tpi_divider.sv -----
// ----------------------------------------------------------------------------
// tpi_divider
// Three-lane restoring divider, one quotient bit per stage, with an entry
// stage that flags quotients that cannot fit in 32 bits.
// ----------------------------------------------------------------------------
module tpi_divider #(
    parameter int NFB = tpi_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  tpi_pkg::tpi_flags_t                  in_flags,
    input  logic [tpi_pkg::tpi_num_w(NFB):0]     np [3],
    input  logic [tpi_pkg::tpi_dv_w(NFB):0]      dp,
    input  logic                                 in_neg [3],
    output logic                                 out_valid,
    output tpi_pkg::tpi_flags_t                  out_flags,
    output logic [tpi_pkg::COORD_W-1:0]          q [3],
    output logic                                 ovf [3],
    output logic                                 out_neg [3]
);
    import tpi_pkg::*;

    localparam int NP_W = tpi_num_w(NFB) + 1;
    localparam int DP_W = tpi_dv_w(NFB) + 1;
    localparam int HI_W = NP_W - COORD_W;

    logic                v_reg   [0:DIV_STEPS];
    tpi_flags_t          fl_reg  [0:DIV_STEPS];
    logic [DP_W-1:0]     dp_reg  [0:DIV_STEPS];
    logic [DP_W-1:0]     rem_reg [0:DIV_STEPS][3];
    logic [COORD_W-1:0]  low_reg [0:DIV_STEPS][3];
    logic [COORD_W-1:0]  q_reg   [0:DIV_STEPS][3];
    logic                ovf_reg [0:DIV_STEPS][3];
    logic                neg_reg [0:DIV_STEPS][3];

    logic [DP_W:0]       wide_rem [1:DIV_STEPS][3];
    logic                ge       [1:DIV_STEPS][3];
    logic [DP_W-1:0]     rem_next [1:DIV_STEPS][3];
    logic                ovf0     [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ovf0[k] = np[k][NP_W-1:COORD_W] >= HI_W'(dp);
        end
        for (int s = 1; s <= DIV_STEPS; s++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                wide_rem[s][k] = {rem_reg[s-1][k], low_reg[s-1][k][COORD_W-1]};
                ge[s][k]       = wide_rem[s][k] >= {1'b0, dp_reg[s-1]};
                rem_next[s][k] = ge[s][k] ? DP_W'(wide_rem[s][k] - {1'b0, dp_reg[s-1]})
                                          : wide_rem[s][k][DP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STEPS; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= DIV_STEPS; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fl_reg[0] <= in_flags;
            dp_reg[0] <= dp;
            for (int k = 0; k < 3; k++)
            begin
                // Without overflow the upper dividend bits sit below the divisor.
                rem_reg[0][k] <= ovf0[k] ? '0 : DP_W'(np[k] >> COORD_W);
                low_reg[0][k] <= np[k][COORD_W-1:0];
                q_reg[0][k]   <= '0;
                ovf_reg[0][k] <= ovf0[k];
                neg_reg[0][k] <= in_neg[k];
            end
            for (int s = 1; s <= DIV_STEPS; s++)
            begin
                fl_reg[s] <= fl_reg[s-1];
                dp_reg[s] <= dp_reg[s-1];
                for (int k = 0; k < 3; k++)
                begin
                    rem_reg[s][k] <= rem_next[s][k];
                    low_reg[s][k] <= low_reg[s-1][k] << 1;
                    q_reg[s][k]   <= {q_reg[s-1][k][COORD_W-2:0], ge[s][k]};
                    ovf_reg[s][k] <= ovf_reg[s-1][k];
                    neg_reg[s][k] <= neg_reg[s-1][k];
                end
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS];
    assign out_flags = fl_reg[DIV_STEPS];
    assign q         = q_reg[DIV_STEPS];
    assign ovf       = ovf_reg[DIV_STEPS];
    assign out_neg   = neg_reg[DIV_STEPS];

endmodule

// ----- test/three_plane_intersection_tb.sv -----
// ----------------------------------------------------------------------------
// three_plane_intersection_tb
// Self-checking bench for the three-plane intersection block. Plane triples
// are sent through the request channel with random gaps when enabled, and every
// result is compared field by field to a bit-exact predictor of the integer math.
// ----------------------------------------------------------------------------
module three_plane_intersection_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpi_pkg::*;

    localparam int NFB = NORMAL_FRAC_BITS_DEF;
    localparam int LATENCY = 40;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        tpi_status_t status;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [MIN_DEN_W-1:0] cfg_wr_data = '0;

    tpi_plane_if planes ();
    tpi_point_if result ();

    three_plane_intersection dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .planes(planes.sink), .result(result.source)
    );

    always #1 clk = ~clk;

    logic [MIN_DEN_W-1:0] min_den_model = MIN_DEN_RESET;
    point_t expected_points[$];
    int mismatches = 0;
    int results_seen = 0;
    int status_count[4] = '{0, 0, 0, 0};
    bit idle_enable = 1'b1;
    bit hold_sink = 1'b0;
    longint cycles = 0;

    // Rounded quotient of a signed numerator by |den| << NFB, clamped to 32 bits.
    function automatic logic signed [31:0] divide_axis(input logic signed [127:0] num,
                                                       input logic signed [63:0] den,
                                                       inout bit sat);
        logic [127:0] mag, dv, q, r;
        bit neg;
        mag = num[127] ? -num : num;
        dv = (den < 0 ? -den : den);
        dv = dv << NFB;
        q = mag / dv;
        r = mag % dv;
        if ((r << 1) >= dv) q = q + 1;
        neg = num[127] ^ den[63];
        if (neg) begin
            if (q > 128'h80000000)
            begin
                sat = 1'b1;
                return 32'sh80000000;
            end
            return -q[31:0];
        end
        if (q > 128'h7FFFFFFF)
        begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        return q[31:0];
    endfunction

    function automatic point_t intersect_planes(input tpi_planes_t p);
        logic signed [63:0] na[3], nb[3], nc[3], l[3], c1[3], c2[3];
        logic signed [63:0] da, db, dc, d0, d1, d2, one, den, nc2;
        logic signed [127:0] num;
        logic signed [31:0] pt[3];
        point_t res;
        bit sat;
        na = '{p.a_normal_x, p.a_normal_y, p.a_normal_z};
        nb = '{p.b_normal_x, p.b_normal_y, p.b_normal_z};
        nc = '{p.c_normal_x, p.c_normal_y, p.c_normal_z};
        da = p.a_distance;
        db = p.b_distance;
        dc = p.c_distance;
        res = '{STATUS_OK, 0, 0, 0};
        sat = 1'b0;
        d0 = na[0]*nb[0] + na[1]*nb[1] + na[2]*nb[2];
        d1 = na[0]*nc[0] + na[1]*nc[1] + na[2]*nc[2];
        d2 = nb[0]*nc[0] + nb[1]*nc[1] + nb[2]*nc[2];
        one = 64'sd1 <<< (2*NFB);
        if (d0 >= one || -d0 >= one || d1 >= one || -d1 >= one
            || d2 >= one || -d2 >= one)
        begin
            res.status = STATUS_PARALLEL;
            return res;
        end
        l[0] = na[1]*nb[2] - na[2]*nb[1];
        l[1] = na[2]*nb[0] - na[0]*nb[2];
        l[2] = na[0]*nb[1] - na[1]*nb[0];
        den = nc[0]*l[0] + nc[1]*l[1] + nc[2]*l[2];
        if ((den < 0 ? -den : den) <= {14'd0, min_den_model})
        begin
            res.status = STATUS_DEGENERATE;
            return res;
        end
        c1[0] = nb[1]*nc[2] - nb[2]*nc[1];
        c1[1] = nb[2]*nc[0] - nb[0]*nc[2];
        c1[2] = nb[0]*nc[1] - nb[1]*nc[0];
        c2[0] = nc[1]*na[2] - nc[2]*na[1];
        c2[1] = nc[2]*na[0] - nc[0]*na[2];
        c2[2] = nc[0]*na[1] - nc[1]*na[0];
        nc2 = nc[0]*nc[0] + nc[1]*nc[1] + nc[2]*nc[2];
        for (int k = 0; k < 3; k++)
        begin
            num = (128'(da * c1[k]) <<< (2*NFB)) + (128'(db * c2[k]) <<< (2*NFB))
                  + 128'(dc * nc2) * 128'(l[k]);
            pt[k] = divide_axis(num, den, sat);
        end
        res.px = pt[0];
        res.py = pt[1];
        res.pz = pt[2];
        res.status = sat ? STATUS_SATURATED : STATUS_OK;
        return res;
    endfunction

    task automatic send_planes(input tpi_planes_t p);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            planes.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        planes.valid <= 1'b1;
        {planes.a_normal_x, planes.a_normal_y, planes.a_normal_z, planes.a_distance,
         planes.b_normal_x, planes.b_normal_y, planes.b_normal_z, planes.b_distance,
         planes.c_normal_x, planes.c_normal_y, planes.c_normal_z, planes.c_distance} <= p;
        @(posedge clk);
        while (!planes.ready) @(posedge clk);
        expected_points.insert(expected_points.size(), intersect_planes(p));
    endtask

    task automatic stop_sending();
        planes.valid <= 1'b0;
    endtask

    // Waits for the pipeline to drain, then lets the tail of the divider settle.
    task automatic drain();
        while (expected_points.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_min_den(input logic [MIN_DEN_W-1:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        min_den_model = v;
    endtask

    function automatic logic signed [15:0] rand_normal(input bit wide);
        if (wide) return 16'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic signed [31:0] rand_distance();
        case ($urandom_range(0, 3))
            0: return 32'($urandom);
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
        endcase
    endfunction

    // Near-orthogonal triples with random tilt reach the full divide path.
    function automatic tpi_planes_t rand_planes(input bit noisy);
        tpi_planes_t p;
        int spread;
        spread = $urandom_range(0, 3) == 0 ? 9000 : 2000;
        p.a_normal_x = 16'(16384 - $urandom_range(0, spread));
        p.a_normal_y = 16'($signed($urandom_range(0, 2*spread)) - spread);
        p.a_normal_z = 16'($signed($urandom_range(0, 2*spread)) - spread);
        p.b_normal_x = 16'($signed($urandom_range(0, 2*spread)) - spread);
        p.b_normal_y = 16'(16384 - $urandom_range(0, spread));
        p.b_normal_z = 16'($signed($urandom_range(0, 2*spread)) - spread);
        p.c_normal_x = 16'($signed($urandom_range(0, 2*spread)) - spread);
        p.c_normal_y = 16'($signed($urandom_range(0, 2*spread)) - spread);
        p.c_normal_z = 16'(($urandom_range(0, 1) ? 16384 : -16384)
                       + $signed($urandom_range(0, spread)) - spread / 2);
        p.a_distance = rand_distance();
        p.b_distance = rand_distance();
        p.c_distance = rand_distance();
        if (noisy)
        begin
            p.a_normal_x = rand_normal($urandom_range(0, 1));
            p.b_normal_z = rand_normal($urandom_range(0, 1));
            p.c_normal_y = rand_normal($urandom_range(0, 1));
            if ($urandom_range(0, 1)) p.c_normal_x = p.a_normal_x;
        end
        return p;
    endfunction

    function automatic tpi_planes_t axis_planes(input int dx, input int dy, input int dz);
        tpi_planes_t p;
        p = '0;
        p.a_normal_x = 16384;
        p.b_normal_y = 16384;
        p.c_normal_z = 16384;
        p.a_distance = dx;
        p.b_distance = dy;
        p.c_distance = dz;
        return p;
    endfunction

    task automatic test_directed();
        tpi_planes_t p;
        send_planes(axis_planes(32'h00010000, -32'sh00020000, 32'h00008000));
        send_planes(axis_planes(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF));
        p = axis_planes(1, 2, 3);
        p.b_normal_x = 16384;
        p.b_normal_y = 0;
        send_planes(p);                       // A and B parallel
        p = axis_planes(5, 6, 7);
        p.c_normal_z = 0;
        p.c_normal_x = 11585;
        p.c_normal_y = 11585;
        send_planes(p);                       // C contains the A-B line direction
        p = '0;
        send_planes(p);                       // all-zero normals: degenerate
        p = axis_planes(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        p.c_normal_z = 60;
        send_planes(p);                       // tiny C normal at full-scale distances
        p = axis_planes(-32'sh7FFFFFFF, 0, 32'h80000000);
        p.c_normal_z = -200;
        send_planes(p);
        p = '1;
        send_planes(p);
        p = '0;
        p.a_normal_x = 16'sh8000;
        p.b_normal_y = 16'sh7FFF;
        p.c_normal_z = 16'sh8000;
        p.a_distance = 32'h55555555;
        p.b_distance = 32'hAAAAAAAA;
        p.c_distance = 32'h12345678;
        send_planes(p);
        p = axis_planes(3, 3, 3);
        p.a_normal_x = 16383;
        p.a_normal_y = 1;
        p.b_normal_x = -1;
        send_planes(p);                       // rounding of odd quotients
        stop_sending();
    endtask

    task automatic test_threshold_settings();
        logic [MIN_DEN_W-1:0] settings[4];
        settings = '{'0, 50'd1 << 42, {MIN_DEN_W{1'b1}}, MIN_DEN_RESET};
        foreach (settings[i])
        begin
            write_min_den(settings[i]);
            send_planes(axis_planes(100, 200, 300));
            repeat (15) send_planes(rand_planes($urandom_range(0, 4) == 0));
            stop_sending();
        end
    endtask

    task automatic test_backpressure();
        hold_sink = 1'b1;
        repeat (80) send_planes(rand_planes(1'b0));
        stop_sending();
    endtask

    task automatic test_random_stream(input int n, input bit gaps);
        idle_enable = gaps;
        for (int i = 0; i < n; i++) send_planes(rand_planes($urandom_range(0, 4) == 0));
        stop_sending();
    endtask

    // Receiver side: random stalls, or one long hold-off when asked.
    initial
    begin
        int stall;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                result.ready <= 1'b0;
                repeat (150) @(posedge clk);
                hold_sink = 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 9);
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        point_t exp_p;
        if (rst_n && result.valid && result.ready)
        begin
            results_seen++;
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end
            else
            begin
                exp_p = expected_points.pop_front();
                status_count[exp_p.status]++;
                if (result.status !== exp_p.status || result.point_x !== exp_p.px
                    || result.point_y !== exp_p.py || result.point_z !== exp_p.pz)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d (%0d,%0d,%0d) got st=%0d (%0d,%0d,%0d)",
                                 exp_p.status, exp_p.px, exp_p.py, exp_p.pz, result.status,
                                 result.point_x, result.point_y, result.point_z);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        planes.valid = 1'b0;
        planes.a_normal_x = '0; planes.a_normal_y = '0; planes.a_normal_z = '0;
        planes.b_normal_x = '0; planes.b_normal_y = '0; planes.b_normal_z = '0;
        planes.c_normal_x = '0; planes.c_normal_y = '0; planes.c_normal_z = '0;
        planes.a_distance = '0; planes.b_distance = '0; planes.c_distance = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_threshold_settings();
        test_backpressure();
        test_random_stream(400, 1'b1);
        test_random_stream(100, 1'b0);
        drain();
        if (expected_points.size() != 0) mismatches++;
        $display("%0d results checked: %0d ok, %0d parallel, %0d degenerate, %0d saturated",
                 results_seen, status_count[0], status_count[1], status_count[2],
                 status_count[3]);
        $display("thresholds swept from zero to full scale, with a long output stall");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
